// ----- design/polled_frame_checker_with_retry_top_defines.svh -----
// assertion macros used by the checker file
`ifndef POLLED_FRAME_CHECKER_WITH_RETRY_TOP_DEFINES_SVH
`define POLLED_FRAME_CHECKER_WITH_RETRY_TOP_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define PFC_ASSERT_IMP(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define PFC_ASSERT_NXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);

`endif

// ----- design/pfc_pkg.sv -----
// shared types, constants and helpers of the polled frame checker
package pfc_pkg;

  localparam int TimeoutW = 16;
  localparam int LimitW   = 4;
  localparam int TallyW   = 5;
  localparam int CfgDataW = 16;
  localparam int CfgIdxW  = 1;

  localparam logic [TimeoutW-1:0] TIMEOUT_RST = 16'd5000;
  localparam logic [LimitW-1:0]   LIMIT_RST   = 4'd3;

  localparam logic [7:0] CHAR_OPEN  = 8'h3C;
  localparam logic [7:0] CHAR_CLOSE = 8'h3E;
  localparam logic [7:0] CHAR_NL    = 8'h0A;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] REG_TIMEOUT = 1'b0;
  localparam logic [CfgIdxW-1:0] REG_LIMIT   = 1'b1;

  typedef enum logic {
    OP_TICK = 1'b0,
    OP_BYTE = 1'b1
  } opcode_t;

  // what one word means to the retry controller
  typedef struct packed {
    logic tick;
    logic newline;
    logic line_good;
  } item_ctl_t;

  // retry controller result for one word
  typedef struct packed {
    logic              send;
    logic              gave;
    logic [TallyW-1:0] tally;
  } retry_res_t;

  // hex digit decode: bit 4 set when the character is a hex digit
  function automatic logic [4:0] hex_decode(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= "0" && c <= "9") r = {1'b1, 4'(c - "0")};
    else if (c >= "a" && c <= "f") r = {1'b1, 4'(c - "a" + 8'd10)};
    else if (c >= "A" && c <= "F") r = {1'b1, 4'(c - "A" + 8'd10)};
    return r;
  endfunction

endpackage

// ----- design/pfc_line_check.sv -----
// line framing and xor check byte tracker
module pfc_line_check
  import pfc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       step,
  input  logic       is_byte,
  input  logic [7:0] rx_byte,
  output logic       newline,
  output logic       line_good
);

  logic       seen_open_r, seen_open_nxt;
  logic       seen_close_r, seen_close_nxt;
  logic       frame_bad_r, frame_bad_nxt;
  logic       hex_done_r, hex_done_nxt;
  logic       body_r, body_nxt;
  logic [7:0] xor_acc_r, xor_acc_nxt;
  logic [7:0] hex_acc_r, hex_acc_nxt;
  logic [4:0] hex_d;

  assign newline   = is_byte && (rx_byte == CHAR_NL);
  assign line_good = seen_open_r && seen_close_r && !frame_bad_r && body_r &&
                     (hex_acc_r == xor_acc_r);
  assign hex_d     = hex_decode(rx_byte);

  // per-byte parse update
  always_comb begin
    seen_open_nxt  = seen_open_r;
    seen_close_nxt = seen_close_r;
    frame_bad_nxt  = frame_bad_r;
    hex_done_nxt   = hex_done_r;
    body_nxt       = body_r;
    xor_acc_nxt    = xor_acc_r;
    hex_acc_nxt    = hex_acc_r;
    if (step && is_byte) begin
      if (newline) begin
        seen_open_nxt  = 1'b0;
        seen_close_nxt = 1'b0;
        frame_bad_nxt  = 1'b0;
        hex_done_nxt   = 1'b0;
        body_nxt       = 1'b0;
        xor_acc_nxt    = 8'd0;
        hex_acc_nxt    = 8'd0;
      end else if (!seen_open_r) begin
        if (rx_byte == CHAR_OPEN) begin
          seen_open_nxt = 1'b1;
          xor_acc_nxt   = rx_byte;
        end else if (rx_byte == CHAR_CLOSE) begin
          frame_bad_nxt = 1'b1;
        end
      end else if (!seen_close_r) begin
        xor_acc_nxt = xor_acc_r ^ rx_byte;
        if (rx_byte == CHAR_CLOSE) seen_close_nxt = 1'b1;
        else body_nxt = 1'b1;
      end else if (!hex_done_r) begin
        if (!hex_d[4]) hex_done_nxt = 1'b1;
        else hex_acc_nxt = {hex_acc_r[3:0], hex_d[3:0]};
      end
    end
  end

  // parse state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_open_r  <= 1'b0;
      seen_close_r <= 1'b0;
      frame_bad_r  <= 1'b0;
      hex_done_r   <= 1'b0;
      body_r       <= 1'b0;
      xor_acc_r    <= 8'd0;
      hex_acc_r    <= 8'd0;
    end else begin
      seen_open_r  <= seen_open_nxt;
      seen_close_r <= seen_close_nxt;
      frame_bad_r  <= frame_bad_nxt;
      hex_done_r   <= hex_done_nxt;
      body_r       <= body_nxt;
      xor_acc_r    <= xor_acc_nxt;
      hex_acc_r    <= hex_acc_nxt;
    end
  end

endmodule

// ----- design/pfc_retry_ctrl.sv -----
// request timeout, retry tally and configuration registers
module pfc_retry_ctrl
  import pfc_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_wdata,
  input  logic                step,
  input  item_ctl_t           item,
  output retry_res_t          res
);

  logic [TimeoutW-1:0] timeout_r;
  logic [LimitW-1:0]   limit_r;
  logic                awaiting_r, awaiting_nxt;
  logic [TimeoutW-1:0] elapsed_r, elapsed_nxt;
  logic [TallyW-1:0]   tally_r, tally_nxt;
  logic [TimeoutW-1:0] elapsed_inc;
  logic [TallyW-1:0]   tally_inc;
  logic                send, gave;

  assign elapsed_inc = (elapsed_r == '1) ? elapsed_r : elapsed_r + 1'b1;
  assign tally_inc   = tally_r + 1'b1;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r <= TIMEOUT_RST;
      limit_r   <= LIMIT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_TIMEOUT: timeout_r <= cfg_wdata[TimeoutW-1:0];
        REG_LIMIT:   limit_r   <= cfg_wdata[LimitW-1:0];
        default:     ;
      endcase
    end
  end

  // timeout and retry decisions
  always_comb begin
    awaiting_nxt = awaiting_r;
    elapsed_nxt  = elapsed_r;
    tally_nxt    = tally_r;
    send         = 1'b0;
    gave         = 1'b0;
    if (item.tick) begin
      if (awaiting_r) begin
        elapsed_nxt = elapsed_inc;
        if (elapsed_inc >= timeout_r) begin
          if (tally_inc <= {1'b0, limit_r}) begin
            tally_nxt   = tally_inc;
            send        = 1'b1;
            elapsed_nxt = '0;
          end else begin
            tally_nxt    = '0;
            awaiting_nxt = 1'b0;
            gave         = 1'b1;
          end
        end
      end else begin
        send         = 1'b1;
        awaiting_nxt = 1'b1;
        elapsed_nxt  = '0;
      end
    end else if (item.newline) begin
      if (item.line_good) begin
        tally_nxt    = '0;
        awaiting_nxt = 1'b0;
      end else begin
        send         = 1'b1;
        awaiting_nxt = 1'b1;
        elapsed_nxt  = '0;
      end
    end
  end

  assign res.send  = send;
  assign res.gave  = gave;
  assign res.tally = tally_nxt;

  // wait state registers, advance once per word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      awaiting_r <= 1'b0;
      elapsed_r  <= '0;
      tally_r    <= '0;
    end else if (step) begin
      awaiting_r <= awaiting_nxt;
      elapsed_r  <= elapsed_nxt;
      tally_r    <= tally_nxt;
    end
  end

endmodule

// ----- design/polled_frame_checker_with_retry_top.sv -----
// Polled frame checker with timeout and retry: top level.
// Input channel (in_valid/in_ready): each word is a one-millisecond tick
// (in_opcode = 0) or a received character (in_opcode = 1, in_rx_byte).
// Result channel (out_valid/out_ready): exactly one result word per input
// word, in order: send request, line done, line ok, gave up, retry count.
// Configuration: cfg_we writes cfg_wdata into register cfg_index
// (0 = timeout in ticks, 1 = retry limit); write only while no word is
// in flight.
// Flow: an accepted word sits in the input register; its result is then
// registered in the result word register and shows on the result port;
// one word per cycle is sustained while the receiver takes each result.
// Reset (rst_n low, synchronous) empties both registers, drops out_valid,
// clears all line and retry state and loads timeout 5000, retry limit 3.
// A stalled receiver holds the result word stable; the input register
// still takes one more word, after which in_ready drops until the result
// is taken.
module polled_frame_checker_with_retry_top
  import pfc_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                in_opcode,
  input  logic [7:0]          in_rx_byte,
  output logic                out_valid,
  input  logic                out_ready,
  output logic                out_send_request,
  output logic                out_line_done,
  output logic                out_line_ok,
  output logic                out_gave_up,
  output logic [TallyW-1:0]   out_retries_used,
  input  logic                cfg_we,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_wdata
);

  logic        s1_valid_r;
  opcode_t     s1_opcode_r;
  logic [7:0]  s1_byte_r;
  logic        step;
  logic        is_byte;
  logic        newline, line_good;
  item_ctl_t   item;
  retry_res_t  res;
  logic        out_valid_r;
  logic        send_r, done_r, ok_r, gave_r;
  logic [TallyW-1:0] tally_r;

  assign step     = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || step;
  assign is_byte  = (s1_opcode_r == OP_BYTE);

  // input word register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_opcode_r <= opcode_t'(in_opcode);
      s1_byte_r   <= in_rx_byte;
    end
  end

  pfc_line_check u_line (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .is_byte   (is_byte),
    .rx_byte   (s1_byte_r),
    .newline   (newline),
    .line_good (line_good)
  );

  assign item.tick      = !is_byte;
  assign item.newline   = newline;
  assign item.line_good = line_good;

  pfc_retry_ctrl u_retry (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .step      (step),
    .item      (item),
    .res       (res)
  );

  // result word register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      send_r  <= res.send;
      done_r  <= newline;
      ok_r    <= newline && line_good;
      gave_r  <= res.gave;
      tally_r <= res.tally;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_send_request = send_r;
  assign out_line_done    = done_r;
  assign out_line_ok      = ok_r;
  assign out_gave_up      = gave_r;
  assign out_retries_used = tally_r;

endmodule

// ----- design/pfc_checker.sv -----
// port-level checks of the frame checker, bound to the top level
`include "polled_frame_checker_with_retry_top_defines.svh"

module pfc_checker
  import pfc_pkg::*;
(
  input logic                clk,
  input logic                rst_n,
  input logic                out_valid,
  input logic                out_ready,
  input logic                out_send_request,
  input logic                out_line_done,
  input logic                out_line_ok,
  input logic                out_gave_up,
  input logic [TallyW-1:0]   out_retries_used
);

  // a stalled result word holds
  `PFC_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_retries_used) && $stable(out_send_request), "result word changed while stalled")

  // a good line clears the tally and needs no resend
  `PFC_ASSERT_IMP(a_ok_clears, out_valid && out_line_ok, out_line_done && !out_send_request && out_retries_used == 5'd0 && !out_gave_up, "good line result inconsistent")

  // a finished line is either good or triggers a resend
  `PFC_ASSERT_IMP(a_done_outcome, out_valid && out_line_done, out_line_ok || out_send_request, "finished line neither good nor resent")

  // giving up clears the tally and sends nothing
  `PFC_ASSERT_IMP(a_gave_up, out_valid && out_gave_up, !out_send_request && !out_line_done && out_retries_used == 5'd0, "give-up result inconsistent")

endmodule

bind polled_frame_checker_with_retry_top pfc_checker u_pfc_checker (.*);

// ----- dv/tb_polled_frame_checker_with_retry_top.sv -----
// testbench for the polled frame checker: mixed tick and line traffic checked word by word
module tb_polled_frame_checker_with_retry_top;
  import pfc_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int QUIET_LIMIT = 1000;

  typedef struct packed {
    opcode_t    op;
    logic [7:0] ch;
  } rx_word_t;

  typedef struct packed {
    logic              send;
    logic              done;
    logic              ok;
    logic              gave;
    logic [TallyW-1:0] tally;
  } frame_result_t;

  typedef enum int {
    FRAME_GOOD,
    FRAME_BADSUM,
    FRAME_EMPTY,
    FRAME_NO_OPEN,
    FRAME_NO_CLOSE,
    FRAME_EARLY_CLOSE,
    FRAME_PREFIX
  } frame_kind_t;

  logic                clk;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic                in_opcode = OP_TICK;
  logic [7:0]          in_rx_byte = 8'h00;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic                out_send_request;
  logic                out_line_done;
  logic                out_line_ok;
  logic                out_gave_up;
  logic [TallyW-1:0]   out_retries_used;
  logic                cfg_we = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index = REG_TIMEOUT;
  logic [CfgDataW-1:0] cfg_wdata = '0;

  polled_frame_checker_with_retry_top DUT (.*);

  // words waiting to be sent and results waiting to arrive
  rx_word_t      pending_words[$];
  frame_result_t pending_results[$];

  // local copy of the checker state and its registers
  logic                waiting_reply;
  logic [15:0]         elapsed_ms;
  logic [TallyW-1:0]   retry_count;
  logic                got_open, got_close, early_close, hex_end, has_body;
  logic [7:0]          run_xor, hex_sum;
  logic [TimeoutW-1:0] cur_timeout;
  logic [LimitW-1:0]   cur_limit;

  int   fail_count = 0;
  int   words_queued = 0;
  int   results_checked = 0;
  int   good_lines = 0, bad_lines = 0, send_count = 0, give_ups = 0;
  int   quiet_cycles = 0;
  bit   tick_mix = 1'b0;
  int   phase_tick_span = 4;
  logic word_taken = 1'b0;
  int   burst_left = 1, gap_left = 0;
  int   ready_ctr = 0, ready_mode = 0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic int hex_digit_value(logic [7:0] c);
    if (c >= "0" && c <= "9") return int'(c) - int'("0");
    if (c >= "a" && c <= "f") return int'(c) - int'("a") + 10;
    if (c >= "A" && c <= "F") return int'(c) - int'("A") + 10;
    return -1;
  endfunction

  function automatic void clear_line_state();
    got_open = 1'b0;
    got_close = 1'b0;
    early_close = 1'b0;
    hex_end = 1'b0;
    has_body = 1'b0;
    run_xor = '0;
    hex_sum = '0;
  endfunction

  // next result word of the checker for one accepted word
  function automatic frame_result_t predict_poll_result(opcode_t op, logic [7:0] ch);
    frame_result_t r;
    int d;
    r = '0;
    if (op == OP_TICK) begin
      if (waiting_reply) begin
        if (elapsed_ms != 16'hFFFF) elapsed_ms = elapsed_ms + 16'd1;
        if (elapsed_ms >= cur_timeout) begin
          retry_count = retry_count + 1'b1;
          if (retry_count <= {1'b0, cur_limit}) begin
            r.send = 1'b1;
            elapsed_ms = '0;
          end else begin
            retry_count = '0;
            waiting_reply = 1'b0;
            r.gave = 1'b1;
          end
        end
      end else begin
        r.send = 1'b1;
        waiting_reply = 1'b1;
        elapsed_ms = '0;
      end
    end else if (ch == CHAR_NL) begin
      r.done = 1'b1;
      waiting_reply = 1'b0;
      if (got_open && got_close && !early_close && has_body && hex_sum == run_xor) begin
        r.ok = 1'b1;
        retry_count = '0;
      end else begin
        // bad line asks for a resend right away
        r.send = 1'b1;
        waiting_reply = 1'b1;
        elapsed_ms = '0;
      end
      clear_line_state();
    end else if (!got_open) begin
      if (ch == CHAR_OPEN) begin
        got_open = 1'b1;
        run_xor = ch;
      end else if (ch == CHAR_CLOSE) begin
        early_close = 1'b1;
      end
    end else if (!got_close) begin
      run_xor = run_xor ^ ch;
      if (ch == CHAR_CLOSE) got_close = 1'b1;
      else has_body = 1'b1;
    end else if (!hex_end) begin
      d = hex_digit_value(ch);
      if (d < 0) hex_end = 1'b1;
      else hex_sum = {hex_sum[3:0], 4'(d)};
    end
    r.tally = retry_count;
    return r;
  endfunction

  task automatic check_field(string name, logic [4:0] want, logic [4:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  // stimulus helpers
  task automatic push_word(opcode_t op, logic [7:0] ch);
    pending_words.push_back('{op, ch});
    words_queued++;
  endtask

  task automatic push_byte(logic [7:0] ch);
    if (tick_mix && $urandom_range(0, 9) == 0) push_word(OP_TICK, 8'($urandom));
    push_word(OP_BYTE, ch);
  endtask

  task automatic push_text(string s);
    foreach (s[i]) push_byte(s[i]);
  endtask

  function automatic logic [7:0] hex_char(logic [3:0] nib, bit upper);
    if (nib < 10) return 8'("0") + nib;
    return (upper ? 8'("A") : 8'("a")) + nib - 8'd10;
  endfunction

  function automatic logic [7:0] rand_plain_byte();
    logic [7:0] b;
    do b = 8'($urandom);
    while (b == CHAR_NL || b == CHAR_OPEN || b == CHAR_CLOSE);
    return b;
  endfunction

  // one line: optional junk, brackets, body, check digits, optional trailer
  task automatic push_frame(frame_kind_t kind);
    logic [7:0] body[$];
    logic [7:0] b, sum, chk;
    int n, style;
    n = (kind == FRAME_EMPTY) ? 0 : $urandom_range(1, 6);
    repeat (n) begin
      do b = 8'($urandom);
      while (b == CHAR_NL || b == CHAR_CLOSE);
      body.push_back(b);
    end
    sum = CHAR_OPEN ^ CHAR_CLOSE;
    foreach (body[i]) sum = sum ^ body[i];
    // steer toward small sums so short and empty digit runs show up
    if (n > 0 && $urandom_range(0, 3) == 0) begin
      b = body[n-1] ^ sum ^ 8'($urandom_range(0, 15));
      if (b != CHAR_NL && b != CHAR_CLOSE) begin
        sum = sum ^ body[n-1] ^ b;
        body[n-1] = b;
      end
    end
    chk = (kind == FRAME_BADSUM) ? sum ^ 8'($urandom_range(1, 255)) : sum;
    if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 3)) push_byte(rand_plain_byte());
    if (kind == FRAME_EARLY_CLOSE) push_byte(CHAR_CLOSE);
    if (kind != FRAME_NO_OPEN) push_byte(CHAR_OPEN);
    foreach (body[i]) push_byte(body[i]);
    if (kind != FRAME_NO_CLOSE) push_byte(CHAR_CLOSE);
    if (kind == FRAME_PREFIX) begin
      case ($urandom_range(0, 2))
        0: push_byte("+");
        1: push_byte("-");
        default: begin
          push_byte("0");
          push_byte($urandom_range(0, 1) ? "x" : "X");
        end
      endcase
    end
    style = $urandom_range(0, 2);
    if (style == 2) repeat ($urandom_range(1, 3)) push_byte(hex_char(4'($urandom), 1'($urandom)));
    if (style != 1 || chk >= 8'd16) push_byte(hex_char(chk[7:4], 1'($urandom)));
    if (style != 1 || chk != 8'd0) push_byte(hex_char(chk[3:0], 1'($urandom)));
    if ($urandom_range(0, 2) == 0) begin
      do b = 8'($urandom);
      while (b == CHAR_NL || hex_digit_value(b) >= 0);
      push_byte(b);
      repeat ($urandom_range(0, 3)) begin
        do b = 8'($urandom);
        while (b == CHAR_NL);
        push_byte(b);
      end
    end
    push_byte(CHAR_NL);
  endtask

  // mostly well-formed lines, with tick runs, broken lines and raw noise
  task automatic fill_random(int n);
    int start, r;
    start = words_queued;
    while (words_queued - start < n) begin
      r = $urandom_range(0, 99);
      if (r < 50) push_frame(FRAME_GOOD);
      else if (r < 60) push_frame(FRAME_BADSUM);
      else if (r < 75) begin
        repeat ($urandom_range(1, phase_tick_span)) push_word(OP_TICK, 8'($urandom));
      end else if (r < 88) begin
        push_frame(frame_kind_t'($urandom_range(FRAME_EMPTY, FRAME_PREFIX)));
      end else begin
        repeat ($urandom_range(1, 6)) begin
          if ($urandom_range(0, 3) == 0) push_word(OP_TICK, 8'($urandom));
          else push_word(OP_BYTE, 8'($urandom));
        end
      end
    end
  endtask

  task automatic wait_idle();
    while (pending_words.size() != 0 || in_valid || pending_results.size() != 0)
      @(negedge clk);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic run_phase(logic [15:0] tmo, logic [15:0] lim_raw, int span, int n);
    wait_idle();
    write_reg(REG_TIMEOUT, tmo);
    write_reg(REG_LIMIT, lim_raw);
    phase_tick_span = span;
    fill_random(n);
  endtask

  // sender: bursts of words separated by random gaps
  always @(negedge clk) begin : drive_in
    rx_word_t w;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || word_taken) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (pending_words.size() > 0) begin
        w = pending_words.pop_front();
        in_opcode <= w.op;
        in_rx_byte <= w.ch;
        in_valid <= 1'b1;
        burst_left--;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 24);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver: always ready, random stalls, or a fixed stall pattern
  always @(negedge clk) begin
    if (ready_ctr % 50 == 0) ready_mode = $urandom_range(0, 2);
    case (ready_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= ($urandom_range(0, 3) != 0);
      default: out_ready <= ((ready_ctr % 7) < 3);
    endcase
    ready_ctr++;
  end

  // monitor: register writes, result checks, predictions
  always @(posedge clk) begin : watch_ports
    frame_result_t want;
    if (!rst_n) begin
      word_taken <= 1'b0;
      waiting_reply = 1'b0;
      elapsed_ms = '0;
      retry_count = '0;
      clear_line_state();
      cur_timeout = TIMEOUT_RST;
      cur_limit = LIMIT_RST;
    end else begin
      word_taken <= in_valid && in_ready;
      if (cfg_we) begin
        if (cfg_index == REG_TIMEOUT) cur_timeout = cfg_wdata[TimeoutW-1:0];
        else if (cfg_index == REG_LIMIT) cur_limit = cfg_wdata[LimitW-1:0];
      end
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          $error("result word arrived with nothing expected");
          fail_count++;
        end else begin
          want = pending_results.pop_front();
          check_field("send_request", want.send, out_send_request);
          check_field("line_done", want.done, out_line_done);
          check_field("line_ok", want.ok, out_line_ok);
          check_field("gave_up", want.gave, out_gave_up);
          check_field("retries_used", want.tally, out_retries_used);
          results_checked++;
          if (want.done) begin
            if (want.ok) good_lines++;
            else bad_lines++;
          end
          send_count += want.send;
          give_ups += want.gave;
        end
      end
      if (in_valid && in_ready)
        pending_results.push_back(predict_poll_result(opcode_t'(in_opcode), in_rx_byte));
    end
  end

  // watchdog on cycles where no word moves
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("watchdog: no word moved for %0d cycles, %0d results outstanding",
               QUIET_LIMIT, pending_results.size());
      $display("== FAIL ==");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int t;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    // reset settings: good line, idle line, empty body, close before open, extreme bytes
    push_word(OP_TICK, 8'h00);
    push_text("<A>43\n");
    push_byte(CHAR_NL);
    push_text("<>02\n");
    push_text("><A>43\n");
    push_byte(CHAR_OPEN);
    push_byte(8'hFF);
    push_byte(8'h00);
    push_byte(CHAR_CLOSE);
    push_text("FD\n");

    tick_mix = 1'b1;
    // zero timeout expires on the first waiting tick, no retries allowed
    run_phase(16'd0, 16'd0, 3, 40);
    // shortest real timeout, most retries, junk in the upper data bits
    run_phase(16'd1, {12'hABC, 4'd15}, 20, 60);
    run_phase(16'd3, (16'($urandom) & 16'hFFF0) | 16'd2, 8, 80);
    t = $urandom_range(2, 12);
    run_phase(16'(t), 16'($urandom), 3 * t, 80);

    // longest timeout: a bad line starts the wait, ticks stay far below it
    run_phase(16'hFFFF, 16'h0000, 4, 0);
    tick_mix = 1'b0;
    push_byte(CHAR_NL);
    repeat (20) push_word(OP_TICK, 8'($urandom));
    tick_mix = 1'b1;
    fill_random(12);

    t = $urandom_range(5, 40);
    run_phase(16'(t), 16'd1, 2 * t + 5, 80);

    wait_idle();
    repeat (4) @(negedge clk);
    $display("sent %0d words over timeouts 0..65535 and retry limits 0..15; %0d results checked",
             words_queued, results_checked);
    $display("lines good %0d, bad %0d; send requests %0d, give-ups %0d; %0d mismatches",
             good_lines, bad_lines, send_count, give_ups, fail_count);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ----- polled_frame_checker_with_retry_top.f -----
+incdir+design
design/pfc_pkg.sv
design/pfc_line_check.sv
design/pfc_retry_ctrl.sv
design/polled_frame_checker_with_retry_top.sv
design/pfc_checker.sv
dv/tb_polled_frame_checker_with_retry_top.sv
